### hdl/string_key_bucket_hash_defines.svh
// Assertion macros for the checker file of string_key_bucket_hash.
// No dependencies; include by bare file name.
`ifndef STRING_KEY_BUCKET_HASH_DEFINES_SVH
`define STRING_KEY_BUCKET_HASH_DEFINES_SVH

// Check a property on every rising clk edge, skipped while reset is low.
`define SKBH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define SKBH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/skbh_pkg.sv
// Shared constants and controller/datapath interface types for string_key_bucket_hash.
// No dependencies.
package skbh_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned HBITS_W    = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned DIV_CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0]  HASH_MOD           = 32'd4294967029;
  localparam logic [WORD_W-1:0]  GOLDEN_MULT        = 32'd2654435769;
  localparam logic [HBITS_W-1:0] WORD_BITS          = 6'd32;
  localparam logic [HBITS_W-1:0] HASH_BITS_RESET    = 6'd5;
  localparam logic [WORD_W-1:0]  BUCKET_COUNT_RESET = 32'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HASH_BITS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic absorb;    // fold key byte into running value
    logic finish;    // register golden product, clear running value
    logic load;      // shift product and load the remainder unit
    logic step;      // one restoring remainder step
    logic put;       // move remainder into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // current step is the last one
  } sts_t;

endpackage

### hdl/string_key_bucket_hash.sv
// Top level of string_key_bucket_hash: joins controller and datapath.
// Depends on skbh_pkg, skbh_ctrl and skbh_datapath.
//
//  channel   direction  handshake              payload
//  in_       slave      in_tvalid/in_tready    in_tdata = key_byte, in_tlast = key_end
//  out_      master     out_tvalid/out_tready  out_tdata = bucket_index
//  cfg_      write      cfg_we                 cfg_idx, cfg_wdata
//
// Key bytes stream back to back while the block is idle. After an end item
// no new item is taken until the golden product is registered, the shift is
// done, the bit-serial remainder unit has run and the index is handed to the
// output register, which waits while that register is full.
// Reset (rst_n low, synchronous) clears the running value and restores
// hash_bits to 5 and bucket_count to 16.
module string_key_bucket_hash (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] key_byte
  input  logic                            in_tlast,   // key_end
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // [31:0] bucket_index
  input  logic                            cfg_we,
  input  logic [skbh_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [31:0]                     cfg_wdata
);

  skbh_pkg::cmd_t cmd;
  skbh_pkg::sts_t sts;

  skbh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  skbh_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .key_byte     (in_tdata),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .bucket_index (out_tdata)
  );

endmodule

### hdl/skbh_datapath.sv
// Datapath of string_key_bucket_hash: running value, golden product, shift,
// bit-serial remainder unit, configuration and output registers. Uses skbh_pkg.
module skbh_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  skbh_pkg::cmd_t                    cmd,
  output skbh_pkg::sts_t                    sts,
  input  logic [skbh_pkg::BYTE_W-1:0]       key_byte,
  input  logic                              cfg_we,
  input  logic [skbh_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [skbh_pkg::WORD_W-1:0]       cfg_wdata,
  output logic [skbh_pkg::WORD_W-1:0]       bucket_index
);

  logic [skbh_pkg::WORD_W-1:0]    k_r, k_nxt;
  logic [skbh_pkg::WORD_W-1:0]    prod_r;
  logic [skbh_pkg::WORD_W-1:0]    rem_r, rem_nxt;
  logic [skbh_pkg::WORD_W-1:0]    dvd_r, dvd_nxt;
  logic [skbh_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [skbh_pkg::WORD_W-1:0]    out_r;
  logic [skbh_pkg::HBITS_W-1:0]   hash_bits_r;
  logic [skbh_pkg::WORD_W-1:0]    bucket_count_r;

  logic [skbh_pkg::WORD_W-1:0]    sum;
  logic [skbh_pkg::WORD_W-1:0]    mult_lo;
  logic [skbh_pkg::HBITS_W-1:0]   bits_sat;
  logic [skbh_pkg::HBITS_W-1:0]   shamt;
  logic [skbh_pkg::WORD_W-1:0]    hashed;
  logic [skbh_pkg::WORD_W:0]      trial;

  // 257*K + b, wrapped to 32 bits
  assign sum = {k_r[skbh_pkg::WORD_W-9:0], 8'h00} + k_r
             + {{(skbh_pkg::WORD_W-skbh_pkg::BYTE_W){1'b0}}, key_byte};

  assign mult_lo = k_r * skbh_pkg::GOLDEN_MULT;

  assign bits_sat = (hash_bits_r > skbh_pkg::WORD_BITS) ? skbh_pkg::WORD_BITS : hash_bits_r;
  assign shamt    = skbh_pkg::WORD_BITS - bits_sat;
  // a shift of 32 empties the word
  assign hashed   = prod_r >> shamt;

  assign trial = {rem_r, dvd_r[skbh_pkg::WORD_W-1]};

  always_comb begin
    k_nxt = k_r;
    if (cmd.absorb) begin
      k_nxt = (sum >= skbh_pkg::HASH_MOD) ? sum - skbh_pkg::HASH_MOD : sum;
    end else if (cmd.finish) begin
      k_nxt = '0;
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      rem_nxt = '0;
      dvd_nxt = hashed;
      cnt_nxt = '0;
    end else if (cmd.step) begin
      if (trial >= {1'b0, bucket_count_r}) begin
        rem_nxt = trial[skbh_pkg::WORD_W-1:0] - bucket_count_r;
      end else begin
        rem_nxt = trial[skbh_pkg::WORD_W-1:0];
      end
      dvd_nxt = {dvd_r[skbh_pkg::WORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign sts.div_last = (cnt_r == {skbh_pkg::DIV_CNT_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r            <= '0;
      hash_bits_r    <= skbh_pkg::HASH_BITS_RESET;
      bucket_count_r <= skbh_pkg::BUCKET_COUNT_RESET;
      cnt_r          <= '0;
    end else begin
      k_r   <= k_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          skbh_pkg::REG_HASH_BITS:    hash_bits_r    <= cfg_wdata[skbh_pkg::HBITS_W-1:0];
          skbh_pkg::REG_BUCKET_COUNT: bucket_count_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    if (cmd.finish) begin
      prod_r <= mult_lo;
    end
    if (cmd.put) begin
      // no buckets: index is zero
      out_r <= (bucket_count_r == '0) ? '0 : rem_r;
    end
  end

  assign bucket_index = out_r;

endmodule

### hdl/skbh_ctrl.sv
// Controller of string_key_bucket_hash: sequences absorb, finish, remainder
// steps and output handoff. Uses skbh_pkg.
module skbh_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            in_tlast,
  output logic            out_tvalid,
  input  logic            out_tready,
  output skbh_pkg::cmd_t  cmd,
  input  skbh_pkg::sts_t  sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_PUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign cmd.absorb = in_acc && !in_tlast;
  assign cmd.finish = in_acc && in_tlast;
  assign cmd.load   = (state_r == S_LOAD);
  assign cmd.step   = (state_r == S_DIV);
  assign cmd.put    = (state_r == S_PUT) && slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.finish) state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_DIV;
      S_DIV:  if (sts.div_last) state_nxt = S_PUT;
      S_PUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.put) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### hdl/skbh_checker.sv
// Port-level checks for string_key_bucket_hash, bound to the top level.
// Depends on string_key_bucket_hash_defines.svh.
`include "string_key_bucket_hash_defines.svh"

module skbh_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [31:0]                     out_tdata
);

  `SKBH_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "out_tvalid high after reset")
  `SKBH_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled item changed")
  `SKBH_ASSERT(a_end_goes_busy, in_tvalid && in_tready && in_tlast |=> !in_tready, "input taken while finishing key")
  `SKBH_ASSERT(a_result_after_busy, $rose(out_tvalid) |-> !$past(in_tready), "result without finish phase")

endmodule

bind string_key_bucket_hash skbh_checker u_skbh_checker (.*);
